// ----- hdl/hlst_pkg.sv -----
`default_nettype none

package hlst_pkg;

  localparam int unsigned NUM_RESOURCES_DEF = 16;
  localparam int unsigned NUM_PROCESSES_DEF = 16;

  localparam int unsigned RES_W      = 4;
  localparam int unsigned PID_W      = 4;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned HOLD_AW    = RES_W + PID_W;
  localparam int unsigned HOLD_DEPTH = 1 << HOLD_AW;

  localparam logic [CNT_W-1:0]      CNT_MAX         = '1;
  localparam logic                  LOCK_MODE_RST   = 1'b1;
  localparam logic [CFG_DATA_W-1:0] INIT_COUNTS_RST = 64'h1111_1111_1111_1111;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACQUIRE = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_RESET   = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOCK_MODE      = 1'b0,
    CFG_INITIAL_COUNTS = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// ----- hdl/hlst_ram.sv -----
`default_nettype none

module hlst_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/hlst_ctrl.sv -----
`default_nettype none

module hlst_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output hlst_pkg::ctrl_cmd_t    cmd_o
);

  import hlst_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_LOOKUP = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign in_ready_o    = (state_q == ST_IDLE);
  assign slot_free     = !out_valid_q || out_ready_i;
  assign cmd_o.capture = in_valid_i && in_ready_o;
  assign cmd_o.commit  = (state_q == ST_LOOKUP) && slot_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.capture) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_to_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_LOOKUP))
    else $error("accepted word did not move the controller to lookup");

  a_commit_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_o)
    else $error("committed operation did not present a result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !cmd_o.commit)
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// ----- hdl/hlst_dp.sv -----
`default_nettype none

module hlst_dp #(
  parameter int unsigned NUM_RESOURCES = hlst_pkg::NUM_RESOURCES_DEF,
  parameter int unsigned NUM_PROCESSES = hlst_pkg::NUM_PROCESSES_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire hlst_pkg::ctrl_cmd_t                  cmd_i,
  input  wire logic [hlst_pkg::KIND_W-1:0]          kind_i,
  input  wire logic [hlst_pkg::RES_W-1:0]           resource_index_i,
  input  wire logic [hlst_pkg::PID_W-1:0]           process_id_i,
  input  wire logic                                 cfg_valid_i,
  input  wire logic [hlst_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [hlst_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic                                      granted_o,
  output logic                                      available_o,
  output logic      [hlst_pkg::CNT_W-1:0]           available_count_o
);

  import hlst_pkg::*;

  localparam int unsigned RES_IDX_W = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
  localparam logic [RES_W:0] RES_LIM = (RES_W + 1)'(NUM_RESOURCES);
  localparam logic [PID_W:0] PID_LIM = (PID_W + 1)'(NUM_PROCESSES);

  logic [KIND_W-1:0]     kind_q;
  logic [RES_W-1:0]      res_q;
  logic [PID_W-1:0]      pid_q;
  logic                  lock_mode_q;
  logic [CFG_DATA_W-1:0] init_counts_q;

  logic [CNT_W-1:0] free_units_q [NUM_RESOURCES];
  logic [CNT_W-1:0] free_units_d [NUM_RESOURCES];
  logic [PID_W-1:0] owner_pid_q  [NUM_RESOURCES];
  logic [PID_W-1:0] owner_pid_d  [NUM_RESOURCES];
  logic [NUM_RESOURCES-1:0] owner_vld_q, owner_vld_d;
  logic [HOLD_DEPTH-1:0]    hold_vld_q;

  logic                 granted_q, granted_d;
  logic                 avail_q, avail_d;
  logic [CNT_W-1:0]     count_q, count_d;

  logic                 res_ok, pid_ok;
  logic [RES_IDX_W-1:0] ridx;
  logic [HOLD_AW-1:0]   hold_addr;
  logic [CNT_W-1:0]     hold_rdata, held, held_d;
  logic                 hold_we, hold_clr;

  assign res_ok    = {1'b0, res_q} < RES_LIM;
  assign pid_ok    = {1'b0, pid_q} < PID_LIM;
  assign ridx      = res_q[RES_IDX_W-1:0];
  assign hold_addr = {res_q, pid_q};
  assign held      = hold_vld_q[hold_addr] ? hold_rdata : '0;

  hlst_ram #(
    .WIDTH (CNT_W),
    .DEPTH (HOLD_DEPTH)
  ) u_hold_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && hold_we),
    .waddr_i (hold_addr),
    .wdata_i (held_d),
    .re_i    (cmd_i.capture),
    .raddr_i ({resource_index_i, process_id_i}),
    .rdata_o (hold_rdata)
  );

  always_comb begin
    free_units_d = free_units_q;
    owner_pid_d  = owner_pid_q;
    owner_vld_d  = owner_vld_q;
    held_d       = held;
    hold_we      = 1'b0;
    hold_clr     = 1'b0;
    granted_d    = 1'b0;
    case (kind_q)
      KIND_RESET: begin
        for (int r = 0; r < NUM_RESOURCES; r++) begin
          free_units_d[r] = init_counts_q[CNT_W*r +: CNT_W];
          owner_pid_d[r]  = '0;
        end
        owner_vld_d = '0;
        hold_clr    = 1'b1;
        granted_d   = 1'b1;
      end
      KIND_ACQUIRE: begin
        if (res_ok && pid_ok) begin
          if (lock_mode_q) begin
            if ((free_units_q[ridx] != '0) && (held != CNT_MAX)) begin
              free_units_d[ridx] = free_units_q[ridx] - 1'b1;
              held_d             = held + 1'b1;
              hold_we            = 1'b1;
              granted_d          = 1'b1;
            end
          end else if (!owner_vld_q[ridx]) begin
            owner_vld_d[ridx] = 1'b1;
            owner_pid_d[ridx] = pid_q;
            granted_d         = 1'b1;
          end
        end
      end
      KIND_RELEASE: begin
        if (res_ok && pid_ok) begin
          if (lock_mode_q) begin
            if ((held != '0) && (free_units_q[ridx] != CNT_MAX)) begin
              free_units_d[ridx] = free_units_q[ridx] + 1'b1;
              held_d             = held - 1'b1;
              hold_we            = 1'b1;
              granted_d          = 1'b1;
            end
          end else if (owner_vld_q[ridx] && (owner_pid_q[ridx] == pid_q)) begin
            owner_vld_d[ridx] = 1'b0;
            granted_d         = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    avail_d = 1'b0;
    count_d = '0;
    if (res_ok) begin
      if (lock_mode_q) begin
        count_d = free_units_d[ridx];
        avail_d = (free_units_d[ridx] != '0);
      end else begin
        avail_d = !owner_vld_d[ridx];
        count_d = {{(CNT_W-1){1'b0}}, !owner_vld_d[ridx]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_mode_q   <= LOCK_MODE_RST;
      init_counts_q <= INIT_COUNTS_RST;
      for (int r = 0; r < NUM_RESOURCES; r++) begin
        free_units_q[r] <= INIT_COUNTS_RST[CNT_W*r +: CNT_W];
        owner_pid_q[r]  <= '0;
      end
      owner_vld_q <= '0;
      hold_vld_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_LOCK_MODE:      lock_mode_q   <= cfg_data_i[0];
          CFG_INITIAL_COUNTS: init_counts_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.commit) begin
        free_units_q <= free_units_d;
        owner_pid_q  <= owner_pid_d;
        owner_vld_q  <= owner_vld_d;
        if (hold_clr) begin
          hold_vld_q <= '0;
        end else if (hold_we) begin
          hold_vld_q[hold_addr] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      res_q  <= resource_index_i;
      pid_q  <= process_id_i;
    end
    if (cmd_i.commit) begin
      granted_q <= granted_d;
      avail_q   <= avail_d;
      count_q   <= count_d;
    end
  end

  assign granted_o         = granted_q;
  assign available_o       = avail_q;
  assign available_count_o = count_q;

endmodule

`default_nettype wire

// ----- hdl/hardware_lock_semaphore_table_unit.sv -----
// Lock table with one mutex or counting semaphore per resource number.
// Input channel (in_valid_i/in_ready_o) carries one word per operation:
// kind_i selects acquire, release or a reset of the whole table, with
// resource_index_i and process_id_i naming the lock and the requester.
// Output channel (out_valid_o/out_ready_i) returns one word per operation
// with granted_o, available_o and available_count_o for that resource.
// The configuration channel writes lock_mode (index 0) and initial_counts
// (index 1); it is always ready, and the user must use it only while the
// table is idle, which the block does not check. The idle state accepts a
// word and reads the per-process hold count memory, whose read port is
// registered; the lookup state updates the table and loads the result
// register, and no new word is taken until that state is left.
// The result register frees the input side, so a new word is taken while
// a result waits; if the receiver stalls, the following operation waits
// in the lookup state until the result register is emptied.
// Reset selects semaphore mode, loads the default counts and frees every
// lock; hold counts are marked empty by a flag per entry, so no clearing
// pass is needed and the table accepts words straight after reset.
`default_nettype none

module hardware_lock_semaphore_table_unit #(
  parameter int unsigned NUM_RESOURCES = hlst_pkg::NUM_RESOURCES_DEF,
  parameter int unsigned NUM_PROCESSES = hlst_pkg::NUM_PROCESSES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [hlst_pkg::KIND_W-1:0]      kind_i,
  input  wire logic [hlst_pkg::RES_W-1:0]       resource_index_i,
  input  wire logic [hlst_pkg::PID_W-1:0]       process_id_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic                                  granted_o,
  output logic                                  available_o,
  output logic      [hlst_pkg::CNT_W-1:0]       available_count_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [hlst_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [hlst_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import hlst_pkg::*;

  ctrl_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  hlst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  hlst_dp #(
    .NUM_RESOURCES (NUM_RESOURCES),
    .NUM_PROCESSES (NUM_PROCESSES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .kind_i            (kind_i),
    .resource_index_i  (resource_index_i),
    .process_id_i      (process_id_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .granted_o         (granted_o),
    .available_o       (available_o),
    .available_count_o (available_count_o)
  );

endmodule

`default_nettype wire

// ----- tb/tb_hardware_lock_semaphore_table_unit.sv -----
`default_nettype none

module tb_hardware_lock_semaphore_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import hlst_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned NUM_RES = NUM_RESOURCES_DEF;
  localparam int unsigned NUM_PROC = NUM_PROCESSES_DEF;
  localparam int unsigned PHASES = 8;
  localparam int unsigned OPS_PER_PHASE = 105;

  typedef struct packed {
    logic             granted;
    logic             available;
    logic [CNT_W-1:0] count;
  } lock_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [KIND_W-1:0]     kind_i = '0;
  logic [RES_W-1:0]      resource_index_i = '0;
  logic [PID_W-1:0]      process_id_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  granted_o;
  logic                  available_o;
  logic [CNT_W-1:0]      available_count_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned words_checked = 0;
  int unsigned grants_seen = 0;

  // Shadow of the lock table, kept in step with accepted words.
  logic                  sem_mode;
  logic [CFG_DATA_W-1:0] counts_cfg;
  logic [CNT_W-1:0]      pool_q [NUM_RES];
  logic [CNT_W-1:0]      held_q [HOLD_DEPTH];
  logic [PID_W-1:0]      owner_pid_q [NUM_RES];
  logic                  owner_set_q [NUM_RES];

  lock_result_t lock_results_due [$];

  hardware_lock_semaphore_table_unit u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .kind_i            (kind_i),
    .resource_index_i  (resource_index_i),
    .process_id_i      (process_id_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .granted_o         (granted_o),
    .available_o       (available_o),
    .available_count_o (available_count_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic void reload_pools();
    for (int r = 0; r < NUM_RES; r++) begin
      pool_q[r] = counts_cfg[4*r +: 4];
      owner_pid_q[r] = '0;
      owner_set_q[r] = 1'b0;
    end
    for (int h = 0; h < HOLD_DEPTH; h++) begin
      held_q[h] = '0;
    end
  endfunction

  function automatic lock_result_t apply_lock_op(input logic [KIND_W-1:0] kind,
                                                 input logic [RES_W-1:0] res,
                                                 input logic [PID_W-1:0] pid);
    lock_result_t r;
    logic [HOLD_AW-1:0] slot;
    r = '0;
    slot = {res, pid};
    if (kind == KIND_RESET) begin
      reload_pools();
      r.granted = 1'b1;
    end else if ((kind == KIND_ACQUIRE || kind == KIND_RELEASE) && res < NUM_RES &&
                 pid < NUM_PROC) begin
      if (sem_mode) begin
        if (kind == KIND_ACQUIRE) begin
          if (pool_q[res] != 0 && held_q[slot] != CNT_MAX) begin
            pool_q[res] = pool_q[res] - 1'b1;
            held_q[slot] = held_q[slot] + 1'b1;
            r.granted = 1'b1;
          end
        end else if (held_q[slot] != 0 && pool_q[res] != CNT_MAX) begin
          held_q[slot] = held_q[slot] - 1'b1;
          pool_q[res] = pool_q[res] + 1'b1;
          r.granted = 1'b1;
        end
      end else begin
        if (kind == KIND_ACQUIRE) begin
          if (!owner_set_q[res]) begin
            owner_set_q[res] = 1'b1;
            owner_pid_q[res] = pid;
            r.granted = 1'b1;
          end
        end else if (owner_set_q[res] && owner_pid_q[res] == pid) begin
          owner_set_q[res] = 1'b0;
          r.granted = 1'b1;
        end
      end
    end
    if (res < NUM_RES) begin
      if (sem_mode) begin
        r.count = pool_q[res];
        r.available = (pool_q[res] != 0);
      end else begin
        r.available = !owner_set_q[res];
        r.count = {{(CNT_W-1){1'b0}}, r.available};
      end
    end
    return r;
  endfunction

  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [RES_W-1:0] res,
                         input logic [PID_W-1:0] pid);
    lock_result_t due;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    resource_index_i <= res;
    process_id_i <= pid;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    due = apply_lock_op(kind, res, pid);
    if (due.granted) grants_seen++;
    lock_results_due.insert(lock_results_due.size(), due);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_LOCK_MODE) sem_mode = data[0];
    else counts_cfg = data;
  endtask

  task automatic wait_table_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (lock_results_due.size() != 0);
  endtask

  task automatic test_semaphore_defaults();
    send_op(KIND_ACQUIRE, 0, 0);
    send_op(KIND_ACQUIRE, 0, 1);
    send_op(KIND_RELEASE, 0, 1);
    send_op(KIND_RELEASE, 0, 0);
    send_op(KIND_UNUSED, 0, 0);
  endtask

  task automatic test_mutex_ownership();
    wait_table_idle();
    write_cfg(CFG_LOCK_MODE, '0);
    cfg_valid_i <= 1'b0;
    send_op(KIND_ACQUIRE, 2, 5);
    send_op(KIND_ACQUIRE, 2, 5);
    send_op(KIND_RELEASE, 2, 6);
    send_op(KIND_RELEASE, 2, 5);
    send_op(KIND_RELEASE, 2, 5);
    send_op(KIND_ACQUIRE, 15, 15);
    send_op(KIND_UNUSED, 15, 0);
    // Back to semaphore mode with the mutex lock still held.
    wait_table_idle();
    write_cfg(CFG_LOCK_MODE, 64'd1);
    cfg_valid_i <= 1'b0;
    send_op(KIND_ACQUIRE, 15, 15);
  endtask

  task automatic test_count_extremes();
    wait_table_idle();
    write_cfg(CFG_INITIAL_COUNTS, 64'h0F0F_0F0F_0F0F_0F0F);
    cfg_valid_i <= 1'b0;
    send_op(KIND_RESET, 4, 9);
    send_op(KIND_ACQUIRE, 1, 0);
    repeat (3) send_op(KIND_ACQUIRE, 0, 3);
    send_op(KIND_RELEASE, 0, 3);
    send_op(KIND_RELEASE, 0, 4);
    wait_table_idle();
    write_cfg(CFG_INITIAL_COUNTS, '1);
    cfg_valid_i <= 1'b0;
    send_op(KIND_RESET, 15, 15);
    send_op(KIND_ACQUIRE, 7, 8);
    wait_table_idle();
    write_cfg(CFG_INITIAL_COUNTS, '0);
    cfg_valid_i <= 1'b0;
    send_op(KIND_RESET, 0, 0);
    send_op(KIND_ACQUIRE, 7, 8);
  endtask

  task automatic test_random_traffic();
    logic [KIND_W-1:0] kind;
    logic [RES_W-1:0] res;
    logic [PID_W-1:0] pid;
    logic [CFG_DATA_W-1:0] counts;
    int unsigned pick;
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_table_idle();
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      case (phase)
        0: counts = '1;
        1: counts = '0;
        2: counts = 64'h2222_2222_2222_2222;
        default: counts = {$urandom, $urandom};
      endcase
      write_cfg(CFG_LOCK_MODE, (phase < 4) ? 64'(phase % 2) : 64'($urandom_range(1)));
      write_cfg(CFG_INITIAL_COUNTS, counts);
      cfg_valid_i <= 1'b0;
      if ($urandom_range(3) != 0)
        send_op(KIND_RESET, RES_W'($urandom_range(15)), PID_W'($urandom_range(15)));
      for (int n = 0; n < OPS_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        if (pick < 46) kind = KIND_ACQUIRE;
        else if (pick < 92) kind = KIND_RELEASE;
        else if (pick < 96) kind = KIND_RESET;
        else kind = KIND_UNUSED;
        res = ($urandom_range(3) == 0) ? RES_W'($urandom_range(15)) :
                                         RES_W'($urandom_range(2));
        pid = ($urandom_range(3) == 0) ? PID_W'($urandom_range(15)) :
                                         PID_W'($urandom_range(3));
        if (kind == KIND_RELEASE && !sem_mode && owner_set_q[res] && $urandom_range(1))
          pid = owner_pid_q[res];
        send_op(kind, res, pid);
        if ($urandom_range(59) == 0) wait_table_idle();
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    lock_result_t due;
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_checked++;
      if (lock_results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Result word with none expected: granted %0b available %0b count %0d",
                   granted_o, available_o, available_count_o);
      end else begin
        due = lock_results_due.pop_front();
        if (granted_o !== due.granted || available_o !== due.available ||
            available_count_o !== due.count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch at %0t: granted %0b/%0b available %0b/%0b count %0d/%0d %s",
                     $realtime, due.granted, granted_o, due.available, available_o,
                     due.count, available_count_o, "(expected/actual)");
        end
      end
    end
  end

  initial begin
    sem_mode = LOCK_MODE_RST;
    counts_cfg = INIT_COUNTS_RST;
    reload_pools();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_semaphore_defaults();
    test_mutex_ownership();
    test_count_extremes();
    test_random_traffic();
    wait_table_idle();
    repeat (4) @(posedge clk_i);
    $display("Checked %0d result words, %0d of them grants, in mutex and semaphore modes",
             words_checked, grants_seen);
    $display("under four idle and stall patterns with table resets and count reloads.");
    if (mismatch_count == 0) begin
      $display("tb_hardware_lock_semaphore_table_unit: done, clean");
    end else begin
      $display("tb_hardware_lock_semaphore_table_unit: done, errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_hardware_lock_semaphore_table_unit: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
